/* sv/assert_macros.svh */
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition in one cycle requires a consequence in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/sha256_pkg.sv */
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Working variables a..h of one compression.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [7:0] PAD_MARKER = 8'h80;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/sha256_stream_hasher.sv */
// SHA-256 hasher for a byte stream.
// Input channel: one item per message byte (s_tuser marks a byte as present);
// s_tlast on an item closes the message, with or without a byte.
// Output channel: eight 32-bit digest words, most significant first, with
// the word index on m_tuser and m_tlast on the eighth word.
// Bytes shift into a 512-bit block register. A byte that fills the block
// starts a compression: 64 rounds through one shared round unit, one per
// cycle, then a fold of the result into the chaining words.
// A closing item pads one byte per cycle (marker, zeros up to byte 56), then
// inserts the bit length and compresses; this gives one or two extra blocks
// before the first digest word.
// s_tready is low from an item that fills the block or ends the message until
// the block is idle again, and while digest words are pending. A stall on
// m_tready holds the current word; after the eighth word is taken the block
// reinitializes for the next message. Reset loads the initial hash values and
// clears the length count.
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast    // last_word
);

  state_t       state;
  state_t       state_next;
  logic [511:0] blk;
  work_t        wv;
  word_t        hv [8];
  logic [5:0]   cnt;
  logic [63:0]  bitlen;
  logic [5:0]   round;
  logic [2:0]   idx;
  logic         closing;
  logic         marked;
  logic         last_blk;

  logic         accept;
  logic         start_round;
  work_t        wv_round;
  word_t        w_new;

  sha256_round u_round (
    .cur   (wv),
    .wt    (blk[511:480]),
    .kt    (round_k(round)),
    .w1    (blk[479:448]),
    .w9    (blk[223:192]),
    .w14   (blk[63:32]),
    .nxt   (wv_round),
    .w_new (w_new)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser[0] && cnt == LAST_POS) begin
            state_next = ST_ROUND;
          end else if (s_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (cnt == LAST_POS || (marked && cnt == LEN_POS)) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round == LAST_POS) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (last_blk) begin
          state_next = ST_OUT;
        end else if (closing) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (m_tready && idx == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = (state == ST_IDLE);
    m_tvalid    = (state == ST_OUT);
    m_tdata     = hv[idx];
    m_tuser     = idx;
    m_tlast     = (idx == 3'd7);
    accept      = s_tvalid && s_tready;
    start_round = (state_next == ST_ROUND) && (state != ST_ROUND);
  end

  // Block register and working variables carry payload only.
  always_ff @(posedge clk) begin
    if (start_round) begin
      wv <= '{a: hv[0], b: hv[1], c: hv[2], d: hv[3],
              e: hv[4], f: hv[5], g: hv[6], h: hv[7]};
    end else if (state == ST_ROUND) begin
      wv <= wv_round;
    end

    case (state)
      ST_IDLE: begin
        if (accept && s_tuser[0]) begin
          blk <= {blk[503:0], s_tdata};
        end
      end
      ST_PAD: begin
        if (!marked) begin
          blk <= {blk[503:0], PAD_MARKER};
        end else if (cnt == LEN_POS) begin
          blk <= {blk[447:0], bitlen};
        end else begin
          blk <= {blk[503:0], 8'h00};
        end
      end
      ST_ROUND: begin
        blk <= {blk[479:0], w_new};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      bitlen   <= '0;
      round    <= '0;
      idx      <= '0;
      closing  <= 1'b0;
      marked   <= 1'b0;
      last_blk <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hv[i] <= init_hash(3'(i));
      end
    end else begin
      state <= state_next;
      if (start_round) begin
        round <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            closing <= s_tlast;
            marked  <= 1'b0;
            if (s_tuser[0]) begin
              cnt    <= cnt + 6'd1;
              bitlen <= bitlen + 64'd8;
            end
          end
        end
        ST_PAD: begin
          if (!marked) begin
            marked <= 1'b1;
            cnt    <= cnt + 6'd1;
          end else if (cnt == LEN_POS) begin
            cnt      <= '0;
            last_blk <= 1'b1;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_ROUND: begin
          round <= round + 6'd1;
        end
        ST_FINAL: begin
          idx   <= '0;
          hv[0] <= hv[0] + wv.a;
          hv[1] <= hv[1] + wv.b;
          hv[2] <= hv[2] + wv.c;
          hv[3] <= hv[3] + wv.d;
          hv[4] <= hv[4] + wv.e;
          hv[5] <= hv[5] + wv.f;
          hv[6] <= hv[6] + wv.g;
          hv[7] <= hv[7] + wv.h;
        end
        ST_OUT: begin
          if (m_tready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              cnt      <= '0;
              bitlen   <= '0;
              closing  <= 1'b0;
              last_blk <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                hv[i] <= init_hash(3'(i));
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/sha256_round.sv */
// One compression round plus one step of the message schedule.
module sha256_round
  import sha256_pkg::*;
(
  input  work_t cur,
  input  word_t wt,
  input  word_t kt,
  input  word_t w1,
  input  word_t w9,
  input  word_t w14,
  output work_t nxt,
  output word_t w_new
);

  function automatic word_t ror(input word_t v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  word_t big0;
  word_t big1;
  word_t choose;
  word_t major;
  word_t t1;
  word_t t2;
  word_t sm0;
  word_t sm1;

  always_comb begin
    big1   = ror(cur.e, 6) ^ ror(cur.e, 11) ^ ror(cur.e, 25);
    choose = (cur.e & cur.f) ^ (~cur.e & cur.g);
    t1     = cur.h + big1 + choose + kt + wt;
    big0   = ror(cur.a, 2) ^ ror(cur.a, 13) ^ ror(cur.a, 22);
    major  = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
    t2     = big0 + major;

    nxt.h = cur.g;
    nxt.g = cur.f;
    nxt.f = cur.e;
    nxt.e = cur.d + t1;
    nxt.d = cur.c;
    nxt.c = cur.b;
    nxt.b = cur.a;
    nxt.a = t1 + t2;

    // Word t+16 of the schedule from words t, t+1, t+9 and t+14.
    sm0   = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
    sm1   = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
    w_new = wt + sm0 + w9 + sm1;
  end

endmodule

/* sv/sha256_checker.sv */
`include "assert_macros.svh"

// Port-level checks of the hasher.
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled digest word stays offered unchanged.
  `CHK_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // No new item is taken while digest words are pending.
  `CHK_ALWAYS(a_no_overlap, clk, rst, !(s_tready && m_tvalid))

  // Digest words follow one another in index order without a gap.
  `CHK_NEXT(a_word_order, clk, rst, m_tvalid && m_tready && !m_tlast,
            m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))

  // The last flag marks exactly the eighth word.
  `CHK_IMPLY(a_last_word, clk, rst, m_tvalid, m_tlast == (m_tuser == 3'd7))

endmodule

bind sha256_stream_hasher sha256_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
